>>> rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and codes for the time-sorted queue with removal by id.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;
   localparam int OCC_W   = 5;
   localparam int CMP_W   = 32;   // width of the shared compare unit

   // request tdata: item_id, item_time
   localparam int REQ_DATA_W = 48;
   // response tdata: removed_id, removed_time, occupancy, padding
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - ID_W - TIME_W - OCC_W;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_INS_RD,
      SQ_INS_CMP,
      SQ_REM_RD,
      SQ_REM_CMP,
      SQ_SHD_RD,
      SQ_SHD_WR,
      SQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] tstamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic equal;
      logic greater_equal;
   } cmp_flags_type;

endpackage

>>> rtl/tsq_ram.sv
// ----------------------------------------------------------------------------
// tsq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tsq_cmp.sv
// ----------------------------------------------------------------------------
// tsq_cmp
// Shared compare unit: equality for id search, greater-or-equal for time order.
// ----------------------------------------------------------------------------
module tsq_cmp (
   input  logic [tsq_pkg::CMP_W-1:0] opa,
   input  logic [tsq_pkg::CMP_W-1:0] opb,
   output tsq_pkg::cmp_flags_type    flags
);

   logic [tsq_pkg::CMP_W:0] diff;

   // subtract once; borrow out gives the ordering
   assign diff = {1'b0, opa} - {1'b0, opb};

   assign flags.greater_equal = ~diff[tsq_pkg::CMP_W];
   assign flags.equal         = (diff[tsq_pkg::CMP_W-1:0] == '0);

endmodule

>>> rtl/time_sorted_queue_remove_by_id_core.sv
// ----------------------------------------------------------------------------
// time_sorted_queue_remove_by_id_core
// Time-ordered entry table with insert and remove-by-id, walked slot by slot
// by a sequencer around one RAM and one shared compare unit.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  req     | in  | item_id, item_time                         | mode
//  rsp     | out | removed_id, removed_time, occupancy, zeros | status
//
// Each slot visited takes a RAM read step, then a compare/write step.
// Insert at position p into n entries moves the entries at or above p up one slot.
// Remove visits every entry whether or not the id is found; full insert skips the walk.
// Reset empties the table at once; slot contents are only read below the count.
// req_tready is high only in idle; a stalled response holds the next result.
// ----------------------------------------------------------------------------
module time_sorted_queue_remove_by_id_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // item_id[15:0], item_time[47:16]
   input  logic        req_tuser,    // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // removed_id[15:0], removed_time[47:16],
                                     // occupancy[52:48], zeros[55:53]
   output logic [1:0]  rsp_tuser     // status[1:0]
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   tsq_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          count_ff, count_in;
   tsq_pkg::mode_type      mode_ff, mode_in;
   tsq_pkg::entry_type     op_ff, op_in;
   tsq_pkg::entry_type     hit_ff, hit_in;
   tsq_pkg::status_type    status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   tsq_pkg::status_type    rsp_status_ff, rsp_status_in;
   tsq_pkg::entry_type     rsp_entry_ff, rsp_entry_in;
   logic [tsq_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   tsq_pkg::entry_type        wr_data;
   logic [AW-1:0]             rd_addr;
   tsq_pkg::entry_type        rd_data;
   logic [tsq_pkg::ENTRY_W-1:0] rd_bits;

   logic [tsq_pkg::CMP_W-1:0] cmp_a, cmp_b;
   tsq_pkg::cmp_flags_type    cmp_flags;

   logic [CW-1:0]             idx_dec, idx_inc;
   logic [CW+tsq_pkg::OCC_W-1:0] count_wide;

   // entry table
   tsq_ram #(
      .WIDTH(tsq_pkg::ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_data = tsq_pkg::entry_type'(rd_bits);

   // share the comparator: ids on remove, times on insert
   always_comb begin
      if (mode_ff == tsq_pkg::MODE_REMOVE) begin
         cmp_a = tsq_pkg::CMP_W'(rd_data.id);
         cmp_b = tsq_pkg::CMP_W'(op_ff.id);
      end else begin
         cmp_a = rd_data.tstamp;
         cmp_b = op_ff.tstamp;
      end
   end

   tsq_cmp u_cmp (
      .opa  (cmp_a),
      .opb  (cmp_b),
      .flags(cmp_flags)
   );

   assign idx_dec = idx_ff - 1'b1;
   assign idx_inc = idx_ff + 1'b1;
   assign count_wide = (CW + tsq_pkg::OCC_W)'(count_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsq_pkg::SQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      op_ff         <= op_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = op_ff;
      rd_addr       = idx_ff[AW-1:0];
      req_tready    = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tsq_pkg::SQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in       = tsq_pkg::mode_type'(req_tuser);
               op_in.id      = req_tdata[15:0];
               op_in.tstamp  = req_tdata[47:16];
               if (tsq_pkg::mode_type'(req_tuser) == tsq_pkg::MODE_REMOVE) begin
                  idx_in   = '0;
                  state_in = tsq_pkg::SQ_REM_RD;
               end else if (count_ff == FULL_COUNT) begin
                  status_in = tsq_pkg::ST_FULL;
                  state_in  = tsq_pkg::SQ_FINISH;
               end else begin
                  idx_in   = count_ff;
                  state_in = tsq_pkg::SQ_INS_RD;
               end
            end
         end

         // insert: idx is the hole; look at the slot below it
         tsq_pkg::SQ_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               count_in  = count_ff + 1'b1;
               status_in = tsq_pkg::ST_INSERTED;
               state_in  = tsq_pkg::SQ_FINISH;
            end else begin
               rd_addr  = idx_dec[AW-1:0];
               state_in = tsq_pkg::SQ_INS_CMP;
            end
         end

         // move a later-or-equal entry up, else drop the new entry in the hole
         tsq_pkg::SQ_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp_flags.greater_equal) begin
               wr_data  = rd_data;
               idx_in   = idx_dec;
               state_in = tsq_pkg::SQ_INS_RD;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = tsq_pkg::ST_INSERTED;
               state_in  = tsq_pkg::SQ_FINISH;
            end
         end

         // remove: search upward from slot 0
         tsq_pkg::SQ_REM_RD: begin
            if (idx_ff == count_ff) begin
               status_in = tsq_pkg::ST_NOT_FOUND;
               state_in  = tsq_pkg::SQ_FINISH;
            end else begin
               state_in = tsq_pkg::SQ_REM_CMP;
            end
         end

         tsq_pkg::SQ_REM_CMP: begin
            if (cmp_flags.equal) begin
               hit_in   = rd_data;
               state_in = tsq_pkg::SQ_SHD_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = tsq_pkg::SQ_REM_RD;
            end
         end

         // close the gap: pull the next entry down into idx
         tsq_pkg::SQ_SHD_RD: begin
            if (idx_inc >= count_ff) begin
               count_in  = count_ff - 1'b1;
               status_in = tsq_pkg::ST_REMOVED;
               state_in  = tsq_pkg::SQ_FINISH;
            end else begin
               rd_addr  = idx_inc[AW-1:0];
               state_in = tsq_pkg::SQ_SHD_WR;
            end
         end

         tsq_pkg::SQ_SHD_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_inc;
            state_in = tsq_pkg::SQ_SHD_RD;
         end

         // hand the result to the output register once it is free
         tsq_pkg::SQ_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_occ_in    = count_wide[tsq_pkg::OCC_W-1:0];
               if (status_ff == tsq_pkg::ST_REMOVED) begin
                  rsp_entry_in = hit_ff;
               end else begin
                  rsp_entry_in = '0;
               end
               state_in = tsq_pkg::SQ_IDLE;
            end
         end

         default: begin
            state_in = tsq_pkg::SQ_IDLE;
         end
      endcase
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{tsq_pkg::RSP_PAD_W{1'b0}}, rsp_occ_ff,
                        rsp_entry_ff.tstamp, rsp_entry_ff.id};

endmodule
